// ----- design/hsl_pkg.sv -----
// shared types and constants of the hsl to rgb converter
`default_nettype none

package hsl_pkg;

    // pipeline depth from input transfer to result register
    localparam int unsigned NUM_STAGES = 5;
    localparam int unsigned NUM_CHAN   = 3;

    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    typedef logic [8:0]  t_hue;    // degrees
    typedef logic [6:0]  t_pct;    // percent
    typedef logic [13:0] t_lvl;    // percent squared, at most 10000
    typedef logic [14:0] t_wide;   // sums up to 20000
    typedef logic [5:0]  t_wgt;    // ramp weight 0..60
    typedef logic [19:0] t_ramp;   // ramp value, at most 600000
    typedef logic [17:0] t_scl;    // ramp * 17 / 64
    typedef logic [7:0]  t_level;  // channel intensity

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;  // stage loads this cycle
    } t_pipe_ctl;

    localparam t_hue  DEG_FULL    = 9'd360;
    localparam t_hue  DEG_SIXTH   = 9'd60;
    localparam t_hue  DEG_THIRD   = 9'd120;
    localparam t_hue  DEG_HALF    = 9'd180;
    localparam t_hue  DEG_2THIRD  = 9'd240;
    localparam t_pct  PCT_FULL    = 7'd100;
    localparam t_pct  PCT_HALF    = 7'd50;
    localparam t_wgt  WGT_FULL    = 6'd60;

    // 255 / 600000 = 17 / (64 * 625); the 625 is a reciprocal multiply
    localparam int unsigned SCL_SHIFT   = 6;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam logic [20:0] RECIP_625   = 21'd1717987;

endpackage

`default_nettype wire

// ----- design/hsl_ifs.sv -----
// stream interfaces for hsl input triples and rgb results
`default_nettype none

interface hsl_in_if;
    import hsl_pkg::*;
    logic valid;
    logic ready;
    t_hue hue_deg;
    t_pct sat_pct;
    t_pct light_pct;

    modport source (output valid, output hue_deg, output sat_pct, output light_pct,
                    input ready);
    modport sink   (input valid, input hue_deg, input sat_pct, input light_pct,
                    output ready);
endinterface

interface rgb_out_if;
    import hsl_pkg::*;
    logic   valid;
    logic   ready;
    t_level red_level;
    t_level green_level;
    t_level blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);
endinterface

`default_nettype wire

// ----- design/hsl_to_rgb_converter.sv -----
// top level of the hsl to rgb converter: stage control and channel instances
// Usage:
//   i_pix carries one hue (degrees), saturation and lightness (percent) per
//   transfer; o_pix returns the matching 8-bit red, green and blue levels.
//   Hue of 360 or more wraps by 360, percentages above 100 clamp to 100.
// An input transfer reaches o_pix after passing through every register stage in order.
// Throughput: one item per cycle while o_pix.ready is high; five register stages,
//   of which the ramp stage holds two narrow multipliers and an add.
// Each stage carries its own valid bit and loads whenever it is empty or the
//   stage after it moves on, so bubbles close up behind a stalled output.
// When o_pix.ready is low the result stage holds its data; i_pix.ready drops
//   only once every stage is full, and nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset. After reset the
//   block accepts input in the first cycle.
`default_nettype none

module hsl_to_rgb_converter
    import hsl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    hsl_in_if.sink      i_pix,
    rgb_out_if.source   o_pix
);

    logic [NUM_STAGES-1:0] r_vld;
    t_pipe_ctl             n_ctl;
    t_hue                  w_hue [NUM_CHAN];
    t_lvl                  w_low;
    t_lvl                  w_span;
    t_level                w_level [NUM_CHAN];

    always_comb begin
        n_ctl.adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_pix.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_ctl.adv[k] = !r_vld[k] || n_ctl.adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_ctl.adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_ctl.adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    hsl_front u_front (
        .i_clk       (i_clk),
        .i_ctl       (n_ctl),
        .i_hue_deg   (i_pix.hue_deg),
        .i_sat_pct   (i_pix.sat_pct),
        .i_light_pct (i_pix.light_pct),
        .o_hue       (w_hue),
        .o_low       (w_low),
        .o_span      (w_span)
    );

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        hsl_chan u_chan (
            .i_clk   (i_clk),
            .i_ctl   (n_ctl),
            .i_hue   (w_hue[c]),
            .i_low   (w_low),
            .i_span  (w_span),
            .o_level (w_level[c])
        );
    end

    assign i_pix.ready       = n_ctl.adv[0];
    assign o_pix.valid       = r_vld[NUM_STAGES-1];
    assign o_pix.red_level   = w_level[CH_RED];
    assign o_pix.green_level = w_level[CH_GREEN];
    assign o_pix.blue_level  = w_level[CH_BLUE];

endmodule

`default_nettype wire

// ----- design/hsl_front.sv -----
// input clamping, hue rotation and the two intermediate levels (stages one and two)
`default_nettype none

module hsl_front
    import hsl_pkg::*;
(
    input  wire         i_clk,
    input  t_pipe_ctl   i_ctl,
    input  t_hue        i_hue_deg,
    input  t_pct        i_sat_pct,
    input  t_pct        i_light_pct,
    output t_hue        o_hue [NUM_CHAN],
    output t_lvl        o_low,
    output t_lvl        o_span
);

    t_hue  n_hue_g;
    t_hue  n_hue [NUM_CHAN];
    t_pct  n_sat;
    t_pct  n_lit;
    t_lvl  n_ls;
    t_wide n_lit100;
    t_wide n_sat100;
    t_wide n_high_w;
    t_lvl  n_high;
    t_wide n_lit200;
    t_wide n_low_w;
    t_lvl  n_low;
    t_lvl  n_span;

    t_hue  r_hue [NUM_CHAN];
    t_lvl  r_high;
    t_wide r_lit200;
    t_lvl  r_low;
    t_lvl  r_span;

    always_comb begin
        n_hue_g = (i_hue_deg >= DEG_FULL) ? i_hue_deg - DEG_FULL : i_hue_deg;
        n_hue[CH_GREEN] = n_hue_g;
        n_hue[CH_RED]   = (n_hue_g < DEG_2THIRD) ? n_hue_g + DEG_THIRD
                                                 : n_hue_g - DEG_2THIRD;
        n_hue[CH_BLUE]  = (n_hue_g >= DEG_THIRD) ? n_hue_g - DEG_THIRD
                                                 : n_hue_g + DEG_2THIRD;

        n_sat = (i_sat_pct > PCT_FULL) ? PCT_FULL : i_sat_pct;
        n_lit = (i_light_pct > PCT_FULL) ? PCT_FULL : i_light_pct;

        n_ls     = t_lvl'(n_lit) * t_lvl'(n_sat);
        n_lit100 = t_wide'(n_lit) * t_wide'(PCT_FULL);
        n_sat100 = t_wide'(n_sat) * t_wide'(PCT_FULL);
        n_lit200 = {n_lit100[13:0], 1'b0};

        // upper level, percent squared
        if (n_lit < PCT_HALF) begin
            n_high_w = n_lit100 + t_wide'(n_ls);
        end else begin
            n_high_w = n_lit100 + n_sat100 - t_wide'(n_ls);
        end
        n_high = n_high_w[13:0];

        n_low_w = r_lit200 - t_wide'(r_high);
        n_low   = n_low_w[13:0];
        n_span  = r_high - n_low;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_hue    <= n_hue;
            r_high   <= n_high;
            r_lit200 <= n_lit200;
        end
        if (i_ctl.adv[1]) begin
            r_low  <= n_low;
            r_span <= n_span;
        end
    end

    assign o_hue  = r_hue;
    assign o_low  = r_low;
    assign o_span = r_span;

endmodule

`default_nettype wire

// ----- design/hsl_chan.sv -----
// one colour channel: ramp weight, ramp value and scaling to 8 bits (stages two to five)
`default_nettype none

module hsl_chan
    import hsl_pkg::*;
(
    input  wire         i_clk,
    input  t_pipe_ctl   i_ctl,
    input  t_hue        i_hue,
    input  t_lvl        i_low,
    input  t_lvl        i_span,
    output t_level      o_level
);

    t_hue        n_back;
    t_wgt        n_wgt;
    t_ramp       n_ramp;
    logic [23:0] n_x17;
    t_scl        n_scl;
    logic [38:0] n_prod;
    t_level      n_level;

    t_wgt        r_wgt;
    t_ramp       r_ramp;
    t_scl        r_scl;
    t_level      r_level;

    always_comb begin
        // rising edge, plateau, falling edge, floor
        n_back = DEG_2THIRD - i_hue;
        if (i_hue < DEG_SIXTH) begin
            n_wgt = i_hue[5:0];
        end else if (i_hue < DEG_HALF) begin
            n_wgt = WGT_FULL;
        end else if (i_hue < DEG_2THIRD) begin
            n_wgt = n_back[5:0];
        end else begin
            n_wgt = '0;
        end

        n_ramp = t_ramp'(i_low) * t_ramp'(WGT_FULL) + t_ramp'(i_span) * t_ramp'(r_wgt);

        n_x17 = {r_ramp, 4'b0000} + {4'b0000, r_ramp};
        n_scl = n_x17[23:SCL_SHIFT];

        // exact floor of r_scl / 625 for every r_scl in range
        n_prod  = {21'd0, r_scl} * {18'd0, RECIP_625};
        n_level = n_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r_wgt <= n_wgt;
        end
        if (i_ctl.adv[2]) begin
            r_ramp <= n_ramp;
        end
        if (i_ctl.adv[3]) begin
            r_scl <= n_scl;
        end
        if (i_ctl.adv[4]) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire
